>>> hw/rtl/aed_pkg.sv
package aed_pkg;

   localparam int AED_MAX_RESULTS = 5;
   localparam int AED_WINDOW      = 4;
   localparam int AED_FIFO_ADDR_W = 4;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CODE_FS  = 8'h1C;
   localparam logic [7:0] CODE_GS  = 8'h1D;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_LF  = 8'h0A;
   localparam logic [7:0] CODE_ES  = 8'h1E;
   localparam logic [7:0] CODE_ESC = 8'h1B;
   localparam logic [7:0] CODE_TAB = 8'h09;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       out_last;
   } aed_result_type;

   typedef struct packed {
      logic [2:0]                            count;
      aed_result_type [AED_MAX_RESULTS-1:0] item;
   } aed_group_type;

   typedef struct packed {
      logic       hold;
      logic [2:0] used;
      logic [7:0] code;
   } aed_match_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } aed_hex_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] value;
   } aed_code_type;

   function automatic aed_hex_type hex_val(input logic [7:0] c);
      aed_hex_type h;
      h.ok    = 1'b1;
      h.value = c[3:0];
      if (c >= "0" && c <= "9") begin
         h.value = c[3:0];
      end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.ok    = 1'b0;
         h.value = 4'd0;
      end
      return h;
   endfunction

   function automatic aed_code_type match_short(input logic [7:0] a, input logic [7:0] b);
      aed_code_type r;
      aed_hex_type  hi;
      aed_hex_type  lo;
      hi      = hex_val(a);
      lo      = hex_val(b);
      r.ok    = 1'b1;
      r.value = {hi.value, lo.value};
      if (a == "F" && b == "S") begin
         r.value = CODE_FS;
      end else if (a == "G" && b == "S") begin
         r.value = CODE_GS;
      end else if (a == "C" && b == "R") begin
         r.value = CODE_CR;
      end else if (a == "L" && b == "F") begin
         r.value = CODE_LF;
      end else if (a == "E" && b == "S") begin
         r.value = CODE_ES;
      end else if (a == "B" && b == "R") begin
         r.value = CH_LT;
      end else if (!(hi.ok && lo.ok)) begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic aed_code_type match_long(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
      aed_code_type r;
      r.ok    = 1'b1;
      r.value = CODE_ESC;
      if (a == "E" && b == "S" && c == "C") begin
         r.value = CODE_ESC;
      end else if (a == "T" && b == "A" && c == "B") begin
         r.value = CODE_TAB;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   // Decision for a candidate starting at b0 with rem bytes available.
   function automatic aed_match_type match_at(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input logic [7:0] b4, input logic [2:0] rem,
                                              input logic last);
      aed_match_type m;
      aed_code_type  s;
      aed_code_type  l;
      s      = match_short(b1, b2);
      l      = match_long(b1, b2, b3);
      m.hold = 1'b0;
      m.used = 3'd1;
      m.code = CH_LT;
      if (b0 != CH_LT) begin
         m.code = b0;
      end else if (rem < 3'd2) begin
         m.hold = !last;
      end else if (b1 == CH_LT) begin
         m.used = 3'd2;
      end else if (rem < 3'd4) begin
         m.hold = !last;
      end else if (b3 == CH_GT) begin
         if (s.ok) begin
            m.code = s.value;
            m.used = 3'd4;
         end
      end else if (rem < 3'd5) begin
         m.hold = !last;
      end else if (b4 == CH_GT) begin
         if (l.ok) begin
            m.code = l.value;
            m.used = 3'd5;
         end
      end
      return m;
   endfunction

endpackage

>>> hw/rtl/aed_decode.sv
module aed_decode
   import aed_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_load,
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   output logic          busy,
   output aed_group_type group
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic [2:0]          pend_count_ff;
   logic [2:0]          pend_count_in;
   logic [7:0]          pend_win_ff [0:AED_WINDOW-1];
   logic [7:0]          pend_win_in [0:AED_WINDOW-1];
   logic [7:0]          win [0:8];
   logic [2:0]          n;
   aed_match_type       cand [0:AED_MAX_RESULTS-1];
   logic [2:0]          pos;
   logic [2:0]          cnt;
   logic                done;
   aed_match_type       m;

   assign busy = in_valid_ff;
   assign n    = pend_count_ff + 3'd1;

   always_comb begin
      for (int k = 0; k < AED_WINDOW; k++) begin
         if (3'(k) < pend_count_ff) begin
            win[k] = pend_win_ff[k];
         end else if (3'(k) == pend_count_ff) begin
            win[k] = in_byte_ff;
         end else begin
            win[k] = 8'h00;
         end
      end
      win[AED_WINDOW] = (pend_count_ff == 3'(AED_WINDOW)) ? in_byte_ff : 8'h00;
      for (int k = AED_WINDOW + 1; k < 9; k++) begin
         win[k] = 8'h00;
      end
   end

   always_comb begin
      for (int s = 0; s < AED_MAX_RESULTS; s++) begin
         cand[s] = match_at(win[s], win[s+1], win[s+2], win[s+3], win[s+4],
                            (3'(s) < n) ? 3'(n - 3'(s)) : 3'd0, in_last_ff);
      end
   end

   always_comb begin
      pos   = 3'd0;
      cnt   = 3'd0;
      done  = 1'b0;
      m     = '0;
      group = '0;
      for (int step = 0; step < AED_MAX_RESULTS; step++) begin
         if (!done) begin
            if (pos >= n) begin
               done = 1'b1;
            end else begin
               m = cand[pos];
               if (m.hold) begin
                  done = 1'b1;
               end else begin
                  group.item[cnt].data = m.code;
                  cnt = cnt + 3'd1;
                  pos = pos + m.used;
               end
            end
         end
      end
      for (int i = 0; i < AED_MAX_RESULTS; i++) begin
         group.item[i].run_last = (cnt != 3'd0) && (3'(i) == cnt - 3'd1);
         group.item[i].out_last = (cnt != 3'd0) && (3'(i) == cnt - 3'd1) && in_last_ff;
      end
      group.count   = in_valid_ff ? cnt : 3'd0;
      pend_count_in = n - pos;
      for (int k = 0; k < AED_WINDOW; k++) begin
         pend_win_in[k] = win[4'(pos) + 4'(k)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_count_ff <= 3'd0;
      end else begin
         in_valid_ff <= in_load;
         if (in_valid_ff) begin
            pend_count_ff <= pend_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= in_byte;
         in_last_ff <= in_last;
      end
      if (in_valid_ff) begin
         pend_win_ff <= pend_win_in;
      end
   end

endmodule

>>> hw/rtl/aed_result_fifo.sv
module aed_result_fifo
   import aed_pkg::*;
#(
   parameter int ADDR_W = AED_FIFO_ADDR_W
) (
   input  logic              clock,
   input  logic              reset,
   input  aed_group_type     group,
   output logic              out_valid,
   input  logic              out_ready,
   output aed_result_type    out_item,
   output logic [ADDR_W:0]   level
);

   localparam int DEPTH = 1 << ADDR_W;

   aed_result_type    mem_ff [0:DEPTH-1];
   logic [ADDR_W-1:0] wr_ptr_ff;
   logic [ADDR_W-1:0] rd_ptr_ff;
   logic [ADDR_W:0]   count_ff;
   logic [ADDR_W:0]   count_in;
   logic              pop;
   logic [ADDR_W-1:0] wr_off [0:DEPTH-1];
   logic              wr_en  [0:DEPTH-1];

   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign pop       = out_valid && out_ready;
   assign count_in  = count_ff + (ADDR_W+1)'(group.count) - (ADDR_W+1)'(pop);

   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         wr_off[j] = ADDR_W'(j) - wr_ptr_ff;
         wr_en[j]  = wr_off[j] < ADDR_W'(group.count);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         if (wr_en[j]) begin
            mem_ff[j] <= group.item[wr_off[j][2:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + ADDR_W'(group.count);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/angle_escape_decoder.sv
// Angle-bracket escape decoder: takes one raw byte per transaction and returns the decoded
// bytes, with run_last marking the last byte caused by an input and out_last the final byte
// of a string. One input byte is accepted per cycle; the results of a byte are written to
// the result queue in the cycle after acceptance, and the queue drains one decoded byte
// per cycle while rsp_ready is high. Input is held off only while the result queue
// (2**FIFO_ADDR_W entries) could not take the worst-case burst of five bytes from the
// byte in flight plus five from a new one.
module angle_escape_decoder
   import aed_pkg::*;
#(
   parameter int FIFO_ADDR_W = AED_FIFO_ADDR_W
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_out_last
);

   localparam int DEPTH = 1 << FIFO_ADDR_W;

   aed_group_type        group;
   aed_result_type       head;
   logic                 busy;
   logic [FIFO_ADDR_W:0] level;
   logic [FIFO_ADDR_W+1:0] committed;

   assign committed = (FIFO_ADDR_W+2)'(level)
                    + (busy ? (FIFO_ADDR_W+2)'(AED_MAX_RESULTS) : '0);
   assign req_ready = committed <= (FIFO_ADDR_W+2)'(DEPTH - AED_MAX_RESULTS);

   aed_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_load (req_valid && req_ready),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .busy    (busy),
      .group   (group)
   );

   aed_result_fifo #(
      .ADDR_W (FIFO_ADDR_W)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .group     (group),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head),
      .level     (level)
   );

   assign rsp_out_byte = head.data;
   assign rsp_run_last = head.run_last;
   assign rsp_out_last = head.out_last;

endmodule

>>> hw/rtl/aed_checker.sv
module aed_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_out_last
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_run_last) && $stable(rsp_out_last))
      else $error("stalled result changed");

   // The final byte of a string always closes the run of its input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> rsp_run_last)
      else $error("out_last without run_last");

   // Results appear only as a consequence of an earlier accepted input.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a prior input transaction");

endmodule

bind angle_escape_decoder aed_checker u_aed_checker (.*);
